FILE: rtl/wru_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wru_pkg
// Shared widths, types and helpers for the weighted rank-one update block.
// ----------------------------------------------------------------------------
package wru_pkg;

  // Sizing of the stored vector and matrix
  localparam int MAX_DIM   = 16;
  localparam int FRAC_BITS = 16;

  // Fixed field widths
  localparam int VAL_W     = 32;   // Q16.16 element and weight
  localparam int ENT_W     = 48;   // Q32.16 matrix entry
  localparam int DIM_W     = 5;
  localparam int FLD_IDX_W = 4;
  localparam int OP_W      = 2;
  localparam int CFG_AW    = 1;
  localparam int CFG_DW    = 5;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 56;
  localparam int DIM_RESET  = 16;

  // Derived sizes
  localparam int IDX_W     = $clog2(MAX_DIM);
  localparam int MAT_DEPTH = MAX_DIM * MAX_DIM;
  localparam int MAT_AW    = $clog2(MAT_DEPTH);
  localparam int PROD_W    = 2 * VAL_W;
  localparam int SUM_W     = PROD_W + 1;

  // Command codes carried in tuser
  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_UPDATE = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] REG_ONLY_UPPER = 1'd0;
  localparam logic [CFG_AW-1:0] REG_DIM_IN_USE = 1'd1;

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [MAT_AW-1:0]        mat_addr_t;
  typedef logic signed [VAL_W-1:0]  val_t;
  typedef logic signed [ENT_W-1:0]  ent_t;

  localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam ent_t ENT_MAX = {1'b0, {(ENT_W-1){1'b1}}};
  localparam ent_t ENT_MIN = {1'b1, {(ENT_W-1){1'b0}}};

  // Request into the multiply-accumulate unit
  typedef struct packed {
    logic load;
    val_t op_a;
    val_t op_b;
    ent_t acc;
  } mac_req_t;

  // Results out of the multiply-accumulate unit
  typedef struct packed {
    val_t factor;
    logic factor_sat;
    ent_t sum;
    logic sum_sat;
  } mac_res_t;

  // Row-major matrix address
  function automatic mat_addr_t mat_addr(idx_t r, idx_t c);
    return MAT_AW'(int'(r) * MAX_DIM + int'(c));
  endfunction

endpackage
`default_nettype wire

FILE: rtl/weighted_rank1_update.sv
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_rank1_update
// Fixed-point accumulator of weighted outer products M += w*v*v^T (only the upper
// triangle if only_upper is set), vector and matrix in RAM, shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Load and clear: result beat in the cycle after the input beat; one per cycle
//   while the result slot is free. Read: a registered RAM read, then S_RD_WAIT.
// Update: per row S_ROW_RD, S_ROW_MUL and S_ROW_FAC form the row factor, then
//   S_COL feeds one entry per cycle into the matrix read-modify-write pipeline,
//   and S_DRAIN waits for it to empty; input is held off for that whole time.
// Reset clears sequencer, output, flag and config registers and per-entry valid
//   bits at once; vector and matrix read as zero right after reset, no clearing pass.
// ----------------------------------------------------------------------------
module weighted_rank1_update
  import wru_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Input beat
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,   // row_index[3:0], col_index[7:4], value[39:8]
  input  wire logic [OP_W-1:0]       s_tuser,   // opcode[1:0]
  // Result beat
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,   // entry_value[47:0], saturated[48]
  // Configuration writes
  input  wire logic                  cfg_we,
  input  wire logic [CFG_AW-1:0]     cfg_addr,
  input  wire logic [CFG_DW-1:0]     cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_WAIT,
    S_ROW_RD,
    S_ROW_MUL,
    S_ROW_FAC,
    S_COL,
    S_DRAIN
  } state_t;

  state_t               state;
  logic                 only_upper;
  logic [DIM_W-1:0]     dim_in_use;
  logic                 sat_flag;
  logic [MAX_DIM-1:0]   vec_valid;
  logic [MAT_DEPTH-1:0] mat_valid;
  logic                 rd_valid;
  logic                 mul_valid;
  ent_t                 out_entry;
  logic                 out_sat;

  idx_t                 y;
  idx_t                 x;
  idx_t                 last_idx;
  val_t                 weight;
  val_t                 factor;
  mat_addr_t            rd_addr;
  mat_addr_t            mul_addr;
  logic                 rd_in_range;
  logic                 vy_ok;
  logic                 vx_ok;
  logic                 mat_ok;

  logic                 in_accept;
  op_t                  in_op;
  logic [FLD_IDX_W-1:0] in_row;
  logic [FLD_IDX_W-1:0] in_col;
  val_t                 in_value;
  idx_t                 in_row_idx;
  idx_t                 in_col_idx;
  logic                 row_ok;
  logic                 col_ok;
  idx_t                 eff_last;
  logic                 vec_we;
  mat_addr_t            mat_raddr;
  logic [VAL_W-1:0]     vy_data;
  logic [VAL_W-1:0]     vx_data;
  logic [ENT_W-1:0]     mat_rdata;
  mac_req_t             mac_req;
  mac_res_t             mac_res;

  // Unpack the input beat
  assign in_op      = op_t'(s_tuser);
  assign in_row     = s_tdata[3:0];
  assign in_col     = s_tdata[7:4];
  assign in_value   = s_tdata[39:8];
  assign in_row_idx = IDX_W'(in_row);
  assign in_col_idx = IDX_W'(in_col);
  assign row_ok     = int'(in_row) < MAX_DIM;
  assign col_ok     = int'(in_col) < MAX_DIM;

  // Take a beat only when idle and the result slot is free or draining
  assign s_tready  = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign in_accept = s_tvalid && s_tready;

  assign m_tdata = {(OUT_DATA_W-ENT_W-1)'(0), out_sat, out_entry};

  // Clamp the side in use and turn it into a last index
  always_comb begin
    if (dim_in_use == '0) begin
      eff_last = '0;
    end else if (int'(dim_in_use) > MAX_DIM) begin
      eff_last = IDX_W'(MAX_DIM - 1);
    end else begin
      eff_last = IDX_W'(int'(dim_in_use) - 1);
    end
  end

  assign vec_we    = in_accept && (in_op == OP_LOAD) && row_ok;
  assign mat_raddr = (state == S_COL) ? mat_addr(y, x) : mat_addr(in_row_idx, in_col_idx);

  // Two copies of the vector: one for the row element, one for the column
  wru_ram #(.WIDTH(VAL_W), .DEPTH(MAX_DIM)) u_vec_row (
    .clk   (clk),
    .we    (vec_we),
    .waddr (in_row_idx),
    .wdata (in_value),
    .raddr (y),
    .rdata (vy_data)
  );

  wru_ram #(.WIDTH(VAL_W), .DEPTH(MAX_DIM)) u_vec_col (
    .clk   (clk),
    .we    (vec_we),
    .waddr (in_row_idx),
    .wdata (in_value),
    .raddr (x),
    .rdata (vx_data)
  );

  wru_ram #(.WIDTH(ENT_W), .DEPTH(MAT_DEPTH)) u_mat (
    .clk   (clk),
    .we    (mul_valid),
    .waddr (mul_addr),
    .wdata (mac_res.sum),
    .raddr (mat_raddr),
    .rdata (mat_rdata)
  );

  // Column products use the row factor; the row factor uses the weight
  always_comb begin
    mac_req.load = rd_valid || (state == S_ROW_MUL);
    mac_req.acc  = mat_ok ? ent_t'(mat_rdata) : '0;
    if (rd_valid) begin
      mac_req.op_a = factor;
      mac_req.op_b = vx_ok ? val_t'(vx_data) : '0;
    end else begin
      mac_req.op_a = vy_ok ? val_t'(vy_data) : '0;
      mac_req.op_b = weight;
    end
  end

  wru_mac u_mac (
    .clk (clk),
    .req (mac_req),
    .res (mac_res)
  );

  // Sequencer, configuration, valid bits and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      m_tvalid   <= 1'b0;
      out_entry  <= '0;
      out_sat    <= 1'b0;
      only_upper <= 1'b1;
      dim_in_use <= DIM_W'(DIM_RESET);
      sat_flag   <= 1'b0;
      vec_valid  <= '0;
      mat_valid  <= '0;
      rd_valid   <= 1'b0;
      mul_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_ONLY_UPPER: only_upper <= cfg_wdata[0];
          REG_DIM_IN_USE: dim_in_use <= cfg_wdata;
          default: ;
        endcase
      end

      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      // Advance the read-modify-write pipeline
      rd_valid  <= (state == S_COL);
      mul_valid <= rd_valid;
      if (mul_valid) begin
        mat_valid[mul_addr] <= 1'b1;
        if (mac_res.sum_sat) begin
          sat_flag <= 1'b1;
        end
      end

      case (state)
        S_IDLE: begin
          if (in_accept) begin
            case (in_op)
              OP_LOAD: begin
                if (row_ok) begin
                  vec_valid[in_row_idx] <= 1'b1;
                end
                m_tvalid  <= 1'b1;
                out_entry <= '0;
                out_sat   <= sat_flag;
              end
              OP_UPDATE: state <= S_ROW_RD;
              OP_READ:   state <= S_RD_WAIT;
              OP_CLEAR: begin
                mat_valid <= '0;
                m_tvalid  <= 1'b1;
                out_entry <= '0;
                out_sat   <= sat_flag;
              end
              default: ;
            endcase
          end
        end
        S_RD_WAIT: begin
          m_tvalid  <= 1'b1;
          out_entry <= (rd_in_range && mat_ok) ? ent_t'(mat_rdata) : '0;
          out_sat   <= sat_flag;
          state     <= S_IDLE;
        end
        S_ROW_RD:  state <= S_ROW_MUL;
        S_ROW_MUL: state <= S_ROW_FAC;
        S_ROW_FAC: begin
          if (mac_res.factor_sat) begin
            sat_flag <= 1'b1;
          end
          state <= S_COL;
        end
        S_COL: begin
          if (x == last_idx) begin
            state <= (y == last_idx) ? S_DRAIN : S_ROW_RD;
          end
        end
        S_DRAIN: begin
          // Wait for the last write-back before reporting the flag
          if (!rd_valid && !mul_valid) begin
            m_tvalid  <= 1'b1;
            out_entry <= '0;
            out_sat   <= sat_flag;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Row and column walk, operands and pipeline addresses
  always_ff @(posedge clk) begin
    vy_ok    <= vec_valid[y];
    vx_ok    <= vec_valid[x];
    mat_ok   <= mat_valid[mat_raddr];
    mul_addr <= rd_addr;

    if (in_accept) begin
      rd_in_range <= row_ok && col_ok;
      if (in_op == OP_UPDATE) begin
        weight   <= in_value;
        last_idx <= eff_last;
        y        <= '0;
      end
    end

    if (state == S_ROW_FAC) begin
      factor <= mac_res.factor;
      x      <= only_upper ? y : '0;
    end

    if (state == S_COL) begin
      rd_addr <= mat_addr(y, x);
      if (x == last_idx) begin
        y <= y + 1'b1;
      end else begin
        x <= x + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/wru_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wru_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module wru_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/wru_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wru_mac
// Shared multiplier with a product register, followed by the floor shift,
// row-factor saturation and saturating accumulate.
// ----------------------------------------------------------------------------
module wru_mac
  import wru_pkg::*;
(
  input  wire logic     clk,
  input  wire mac_req_t req,
  output mac_res_t      res
);

  logic signed [PROD_W-1:0] prod;
  ent_t                     acc;
  logic signed [PROD_W-1:0] shifted;
  logic [PROD_W-VAL_W:0]    hi_f;
  logic signed [SUM_W-1:0]  sum;
  logic [SUM_W-ENT_W:0]     hi_s;

  // Register the product and the entry it will be added to
  always_ff @(posedge clk) begin
    if (req.load) begin
      prod <= PROD_W'(req.op_a) * PROD_W'(req.op_b);
      acc  <= req.acc;
    end
  end

  // Floor shift, then saturate to the factor and entry ranges
  always_comb begin
    shifted = prod >>> FRAC_BITS;
    hi_f    = shifted[PROD_W-1:VAL_W-1];
    sum     = SUM_W'(shifted) + SUM_W'(acc);
    hi_s    = sum[SUM_W-1:ENT_W-1];

    res.factor_sat = !((&hi_f) || !(|hi_f));
    if (!res.factor_sat) begin
      res.factor = shifted[VAL_W-1:0];
    end else if (shifted[PROD_W-1]) begin
      res.factor = VAL_MIN;
    end else begin
      res.factor = VAL_MAX;
    end

    res.sum_sat = !((&hi_s) || !(|hi_s));
    if (!res.sum_sat) begin
      res.sum = sum[ENT_W-1:0];
    end else if (sum[SUM_W-1]) begin
      res.sum = ENT_MIN;
    end else begin
      res.sum = ENT_MAX;
    end
  end

endmodule
`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for weighted_rank1_update. Streams load, update, read
// and clear commands into the block, tracks the vector, the matrix and the
// sticky saturation flag in a fixed-point predictor, and compares every
// result beat field by field. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import wru_pkg::*;

  localparam val_t ONE_Q16       = 32'sh0001_0000;
  localparam val_t MINUS_ONE_Q16 = -32'sh0001_0000;

  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 8;
  localparam int PHASE_ITEMS  = 125;
  localparam int SAT_ITEMS    = 90;
  localparam int N_PHASES     = 8;
  localparam int PH_UPPER [N_PHASES] = '{0, 1, 0, 1, 0, 1, 1, 0};
  localparam int PH_DIM   [N_PHASES] = '{3, 1, 16, 0, 31, 2, 17, 5};

  typedef struct packed {
    ent_t entry;
    logic sat;
  } rank1_result_t;

  // Fixed-point tracker of vector, matrix and flag; queues expected beats
  class rank1_tracker;
    val_t             vec_q [MAX_DIM];
    ent_t             mat_q [MAT_DEPTH];
    logic             sat_flag;
    logic             upper_only;
    logic [DIM_W-1:0] dim_reg;
    rank1_result_t    awaited [$];
    int               errors;

    function new();
      foreach (vec_q[i]) vec_q[i] = '0;
      foreach (mat_q[i]) mat_q[i] = '0;
      sat_flag   = 1'b0;
      upper_only = 1'b1;
      dim_reg    = DIM_W'(DIM_RESET);
      errors     = 0;
    endfunction

    // Zero acts as one, anything above the store size as the full size
    function int eff_dim();
      if (dim_reg == 0) return 1;
      if (dim_reg > MAX_DIM) return MAX_DIM;
      return int'(dim_reg);
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
      if (idx == REG_ONLY_UPPER) upper_only = data[0];
      else dim_reg = data[DIM_W-1:0];
    endfunction

    // M += w * v * v^T with floor shifts and saturation of factor and sum
    function void apply_rank1(val_t w);
      int     n, y, x, a;
      longint f, p, s;
      n = eff_dim();
      for (y = 0; y < n; y++) begin
        f = (longint'(vec_q[y]) * longint'(w)) >>> FRAC_BITS;
        if (f > longint'(VAL_MAX)) begin
          f = longint'(VAL_MAX);
          sat_flag = 1'b1;
        end else if (f < longint'(VAL_MIN)) begin
          f = longint'(VAL_MIN);
          sat_flag = 1'b1;
        end
        for (x = upper_only ? y : 0; x < n; x++) begin
          a = y * MAX_DIM + x;
          p = (f * longint'(vec_q[x])) >>> FRAC_BITS;
          s = longint'(mat_q[a]) + p;
          if (s > longint'(ENT_MAX)) begin
            s = longint'(ENT_MAX);
            sat_flag = 1'b1;
          end else if (s < longint'(ENT_MIN)) begin
            s = longint'(ENT_MIN);
            sat_flag = 1'b1;
          end
          mat_q[a] = ent_t'(s);
        end
      end
    endfunction

    function void note_command(op_t op, idx_t row, idx_t col, val_t value);
      rank1_result_t r;
      r.entry = '0;
      case (op)
        OP_LOAD:   vec_q[row] = value;
        OP_UPDATE: apply_rank1(value);
        OP_READ:   r.entry = mat_q[int'(row) * MAX_DIM + int'(col)];
        OP_CLEAR:  foreach (mat_q[i]) mat_q[i] = '0;
        default: ;
      endcase
      r.sat = sat_flag;
      awaited.insert(awaited.size(), r);
    endfunction

    function void check_beat(logic [OUT_DATA_W-1:0] data);
      rank1_result_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, actual %h", $time, data);
        return;
      end
      want = awaited.pop_front();
      if (data[ENT_W-1:0] !== want.entry) begin
        errors++;
        $display("%0t: entry_value mismatch, expected %h, actual %h",
                 $time, want.entry, data[ENT_W-1:0]);
      end
      if (data[ENT_W] !== want.sat) begin
        errors++;
        $display("%0t: saturated mismatch, expected %b, actual %b",
                 $time, want.sat, data[ENT_W]);
      end
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;  // row_index[3:0], col_index[7:4], value[39:8]
  logic [OP_W-1:0]       s_tuser   = '0;  // opcode[1:0]
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;         // entry_value[47:0], saturated[48]
  logic                  cfg_we    = 1'b0;
  logic [CFG_AW-1:0]     cfg_addr  = '0;
  logic [CFG_DW-1:0]     cfg_wdata = '0;

  rank1_tracker tracker = new();
  int           sent       = 0;
  int           cycles     = 0;
  int           stall_left = 0;
  bit           quiet      = 1'b0;
  bit           full_range = 1'b0;
  bit           hold_req   = 1'b0;

  weighted_rank1_update dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Check result beats and drive the receiver's ready with random stalls
  always @(posedge clk) begin : sink
    int unsigned r;
    if (!rst && m_tvalid && m_tready) tracker.check_beat(m_tdata);
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req   = 1'b0;
      stall_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (quiet) begin
      m_tready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3) stall_left = $urandom_range(10, 40);
      m_tready <= (r >= 3) && (r < 80);
    end
  end

  // Drop valid for a random gap: mostly none, sometimes short, rarely long
  task automatic pace();
    int unsigned r, n;
    if (quiet) return;
    r = $urandom_range(0, 99);
    if (r < 65) n = 0;
    else if (r < 95) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 40);
    if (n != 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Offer one command beat and hold it until accepted
  task automatic send(op_t op, idx_t row, idx_t col, val_t value);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {value, col, row};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.note_command(op, row, col, value);
    sent++;
    pace();
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain();
    s_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    tracker.write_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Moderate values keep sums far from the 48-bit limits
  function automatic val_t pick_value();
    if (full_range) return val_t'($urandom);
    return val_t'(int'($urandom_range(0, 2097151)) - 1048576);
  endfunction

  function automatic val_t pick_weight();
    case ($urandom_range(0, 7))
      0:       return ONE_Q16;
      1:       return MINUS_ONE_Q16;
      2:       return val_t'(int'($urandom_range(0, 7)) - 4);
      default: return pick_value();
    endcase
  endfunction

  // Mostly inside the active block, sometimes anywhere
  function automatic idx_t pick_index(int n);
    if ($urandom_range(0, 3) != 0) return idx_t'($urandom_range(0, n - 1));
    return idx_t'($urandom);
  endfunction

  task automatic noise_item();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) send(OP_CLEAR, idx_t'($urandom), idx_t'($urandom), val_t'($urandom));
    else if (r < 4) send(OP_UPDATE, idx_t'($urandom), idx_t'($urandom), pick_weight());
    else send(OP_READ, idx_t'($urandom), idx_t'($urandom), val_t'($urandom));
  endtask

  // Load the vector, apply a weighted update, read some entries back
  task automatic run_frame();
    int n, i, k;
    n = tracker.eff_dim();
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) noise_item();
      if ($urandom_range(0, 4) != 0)
        send(OP_LOAD, idx_t'(i), idx_t'($urandom), pick_value());
    end
    // elements past the active size are stored but must not take part
    if (n < MAX_DIM && $urandom_range(0, 2) == 0)
      send(OP_LOAD, idx_t'($urandom_range(n, MAX_DIM - 1)), idx_t'($urandom),
           val_t'($urandom));
    send(OP_UPDATE, idx_t'($urandom), idx_t'($urandom), pick_weight());
    k = $urandom_range(1, 5);
    for (i = 0; i < k; i++)
      send(OP_READ, pick_index(n), pick_index(n), val_t'($urandom));
  endtask

  task automatic reload_vector();
    int i;
    for (i = 0; i < MAX_DIM; i++)
      send(OP_LOAD, idx_t'(i), idx_t'($urandom), pick_value());
  endtask

  // Field extremes, every command, floor of negative products, lower triangle
  task automatic directed_checks();
    send(OP_READ, 0, 0, 0);
    send(OP_LOAD, 0, 15, VAL_MAX);
    send(OP_LOAD, 15, 0, VAL_MIN);
    send(OP_READ, 15, 15, VAL_MAX);
    send(OP_LOAD, 0, 0, 32'sd1);
    send(OP_LOAD, 1, 0, -32'sd1);
    send(OP_LOAD, 2, 0, ONE_Q16);
    send(OP_LOAD, 15, 0, 32'sd0);
    send(OP_UPDATE, 0, 0, VAL_MAX);
    send(OP_UPDATE, 15, 15, VAL_MIN);
    send(OP_UPDATE, 0, 0, ONE_Q16);
    send(OP_UPDATE, 0, 0, MINUS_ONE_Q16);
    send(OP_READ, 0, 0, 0);
    send(OP_READ, 0, 1, 0);
    send(OP_READ, 1, 0, 0);
    send(OP_READ, 1, 1, 0);
    send(OP_READ, 2, 2, 0);
    send(OP_READ, 0, 2, 0);
    send(OP_READ, 2, 0, 0);
    send(OP_READ, 15, 15, 0);
    send(OP_CLEAR, 0, 0, 0);
    send(OP_READ, 2, 2, 0);
  endtask

  // Drive factor and sum into saturation, then full-range random content
  task automatic saturation_checks();
    int y, x, start;
    write_reg(REG_ONLY_UPPER, CFG_DW'(0));
    write_reg(REG_DIM_IN_USE, CFG_DW'(3));
    send(OP_LOAD, 0, 0, VAL_MAX);
    send(OP_LOAD, 1, 0, VAL_MIN);
    send(OP_LOAD, 2, 0, ONE_Q16);
    send(OP_READ, 0, 0, 0);
    repeat (3) send(OP_UPDATE, 0, 0, VAL_MAX);
    for (y = 0; y < 3; y++)
      for (x = 0; x < 3; x++)
        send(OP_READ, idx_t'(y), idx_t'(x), 0);
    // the flag survives a clear
    send(OP_CLEAR, 0, 0, 0);
    send(OP_READ, 0, 0, 0);
    full_range = 1'b1;
    start = sent;
    while (sent < start + SAT_ITEMS) run_frame();
  endtask

  initial begin
    int ph, phase_end, mid;
    bit paused;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_checks();
    drain();

    // Sweep register settings; hold off the receiver in the second one
    for (ph = 0; ph < N_PHASES; ph++) begin
      write_reg(REG_ONLY_UPPER, CFG_DW'(PH_UPPER[ph]));
      write_reg(REG_DIM_IN_USE, CFG_DW'(PH_DIM[ph]));
      quiet = ($urandom_range(0, 3) == 0);
      if (ph == 1) hold_req = 1'b1;
      reload_vector();
      phase_end = sent + PHASE_ITEMS;
      mid       = sent + PHASE_ITEMS / 2;
      paused    = 1'b0;
      while (sent < phase_end) begin
        run_frame();
        if (!paused && sent >= mid) begin
          drain();
          paused = 1'b1;
        end
      end
      drain();
    end

    quiet = 1'b0;
    saturation_checks();
    drain();

    if (tracker.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
